>>> rtl/rotary_sin_cos_table_core_defines.svh
// Assertion macros for the rotary sine/cosine table core.
// Needs clk_i and rst_ni in the module that uses them.
`ifndef ROTARY_SIN_COS_TABLE_CORE_DEFINES_SVH
`define ROTARY_SIN_COS_TABLE_CORE_DEFINES_SVH

// same-cycle implication
`define RSCT_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rsct assertion failed");

// next-cycle implication
`define RSCT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rsct assertion failed");

`endif

>>> rtl/rsct_pkg.sv
// Package for the rotary sine/cosine table core: register codes and
// fixed-point constants. No dependencies.
`timescale 1ns / 1ps

package rsct_pkg;

  typedef enum logic [1:0] {
    REG_THETA = 2'd0,
    REG_PAIRS = 2'd1
  } cfg_reg_e;

  localparam int unsigned PC_W        = 7;
  localparam int unsigned FREQ_W      = 48;
  localparam int unsigned CW          = 34;
  localparam int unsigned CORDIC_STEPS = 16;

  localparam logic [31:0] ONE_Q31        = 32'h8000_0000;
  localparam logic [31:0] INV_TWO_PI_Q32 = 32'd683565276;
  localparam logic [31:0] CORDIC_GAIN    = 32'd652032874;

  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C
  };

endpackage

>>> rtl/rotary_sin_cos_table_core.sv
// Rotary position embedding sine/cosine table generator, top level.
// Depends on rsct_pkg and rotary_sin_cos_table_core_defines.svh.
`timescale 1ns / 1ps
`include "rotary_sin_cos_table_core_defines.svh"

// Takes one token position per input beat and emits pair_count result beats,
// one per frequency index i, each carrying sin and cos (Q1.15) of
// position * ratio^i reduced modulo one turn, ratio being the per-index
// frequency ratio register, with last set on the final pair. A position
// occupies the sequencer until all its pairs (up to MAX_PAIRS) have issued;
// its running-power multiply issues one pair a cycle while the output beat
// is not held, so a new position is taken in the cycle after its predecessor's
// last pair issues. Results leave a 13-stage pipeline (issue, frequency
// multiply, phase multiply, half-turn fold, eight stages of two CORDIC steps,
// output rounding) that stalls as a whole only when the output beat is held.
// Write configuration only while idle.
module rotary_sin_cos_table_core #(
  parameter int unsigned MAX_PAIRS     = 64,
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [1:0]                           cfg_index_i,
  input  logic [31:0]                          cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [POSITION_BITS-1:0]             position_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [15:0]                   sin_value_o,
  output logic signed [15:0]                   cos_value_o,
  output logic [((MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1)-1:0] pair_index_o,
  output logic                                 last_o
);

  localparam int unsigned IDX_W = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_PAIRS + 1);
  localparam int unsigned PH_W  = POSITION_BITS + rsct_pkg::FREQ_W;
  localparam int unsigned CW    = rsct_pkg::CW;
  localparam int unsigned NCS   = rsct_pkg::CORDIC_STEPS / 2;

  // configuration registers
  logic [31:0]              theta_q;
  logic [rsct_pkg::PC_W-1:0] pairs_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      theta_q <= rsct_pkg::ONE_Q31;
      pairs_q <= rsct_pkg::PC_W'(64);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rsct_pkg::REG_THETA: theta_q <= cfg_data_i;
        rsct_pkg::REG_PAIRS: pairs_q <= cfg_data_i[rsct_pkg::PC_W-1:0];
        default: ;
      endcase
    end
  end

  // whole pipeline advances unless the output beat is held
  logic en;
  assign en = !out_valid_o || out_ready_i;

  // sequencer: holds position, running power and index
  logic                     busy_q;
  logic [POSITION_BITS-1:0] pos_q;
  logic [31:0]              pow_q, pow_d;
  logic [IDX_W-1:0]         idx_q;
  logic [CNT_W-1:0]         cnt_q;
  logic [rsct_pkg::PC_W-1:0] cnt_eff;
  logic [31:0]              theta_eff;
  logic [63:0]              pow_prod;
  logic                     issue, issue_last;

  assign in_ready_o = !busy_q;
  assign issue      = busy_q && en;
  assign issue_last = (CNT_W'(idx_q) + CNT_W'(1)) == cnt_q;
  assign theta_eff  = (theta_q > rsct_pkg::ONE_Q31) ? rsct_pkg::ONE_Q31 : theta_q;
  assign pow_prod   = ({32'd0, pow_q} * {32'd0, theta_eff}) + 64'h0000_0000_4000_0000;
  assign pow_d      = pow_prod[62:31];

  always_comb begin
    if (pairs_q == '0) begin
      cnt_eff = rsct_pkg::PC_W'(1);
    end else if (pairs_q > rsct_pkg::PC_W'(MAX_PAIRS)) begin
      cnt_eff = rsct_pkg::PC_W'(MAX_PAIRS);
    end else begin
      cnt_eff = pairs_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pow_q  <= rsct_pkg::ONE_Q31;
      idx_q  <= '0;
      cnt_q  <= '0;
      pos_q  <= '0;
    end else if (in_valid_i && in_ready_o) begin
      busy_q <= 1'b1;
      pow_q  <= rsct_pkg::ONE_Q31;
      idx_q  <= '0;
      cnt_q  <= CNT_W'(cnt_eff);
      pos_q  <= position_i;
    end else if (issue) begin
      // advance the running power; drop back to idle after the last pair
      if (issue_last) begin
        busy_q <= 1'b0;
        pow_q  <= rsct_pkg::ONE_Q31;
        idx_q  <= '0;
      end else begin
        pow_q <= pow_d;
        idx_q <= idx_q + IDX_W'(1);
      end
    end
  end

  // stage A: issued pair
  logic                     a_v_q, a_last_q;
  logic [31:0]              a_pow_q;
  logic [POSITION_BITS-1:0] a_pos_q;
  logic [IDX_W-1:0]         a_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (en) begin
      a_v_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_pow_q  <= pow_q;
      a_pos_q  <= pos_q;
      a_idx_q  <= idx_q;
      a_last_q <= issue_last;
    end
  end

  // stage B: frequency in turns, Q0.48
  logic [63:0]              f_prod;
  logic                     b_v_q, b_last_q;
  logic [rsct_pkg::FREQ_W-1:0] b_freq_q;
  logic [POSITION_BITS-1:0] b_pos_q;
  logic [IDX_W-1:0]         b_idx_q;

  assign f_prod = ({32'd0, a_pow_q} * {32'd0, rsct_pkg::INV_TWO_PI_Q32})
                  + 64'h0000_0000_0000_4000;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (en) begin
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_freq_q <= f_prod[62:15];
      b_pos_q  <= a_pos_q;
      b_idx_q  <= a_idx_q;
      b_last_q <= a_last_q;
    end
  end

  // stage C: phase, keep the top 32 bits of the 48-bit turn fraction
  logic [PH_W-1:0] ph_prod;
  logic            c_v_q, c_last_q;
  logic [31:0]     c_ph_q;
  logic [IDX_W-1:0] c_idx_q;

  assign ph_prod = PH_W'(b_pos_q) * PH_W'(b_freq_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else if (en) begin
      c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_ph_q   <= ph_prod[47:16];
      c_idx_q  <= b_idx_q;
      c_last_q <= b_last_q;
    end
  end

  // stage D: fold into [-quarter, quarter] turn, flip signs if folded
  logic signed [CW-1:0] z_raw, z_fold;
  logic                 fold;

  assign z_raw = CW'($signed(c_ph_q));

  always_comb begin
    fold   = 1'b0;
    z_fold = z_raw;
    if (z_raw > CW'(64'sd1073741824)) begin
      fold   = 1'b1;
      z_fold = z_raw - CW'(64'sd2147483648);
    end else if (z_raw < -CW'(64'sd1073741824)) begin
      fold   = 1'b1;
      z_fold = z_raw + CW'(64'sd2147483648);
    end
  end

  logic                 cv_q   [NCS+1];
  logic                 cl_q   [NCS+1];
  logic                 cf_q   [NCS+1];
  logic [IDX_W-1:0]     ci_q   [NCS+1];
  logic signed [CW-1:0] cx_q   [NCS+1];
  logic signed [CW-1:0] cy_q   [NCS+1];
  logic signed [CW-1:0] cz_q   [NCS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q[0] <= 1'b0;
    end else if (en) begin
      cv_q[0] <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cx_q[0] <= CW'(rsct_pkg::CORDIC_GAIN);
      cy_q[0] <= '0;
      cz_q[0] <= z_fold;
      cf_q[0] <= fold;
      ci_q[0] <= c_idx_q;
      cl_q[0] <= c_last_q;
    end
  end

  // CORDIC: two rotation steps per stage
  for (genvar s = 0; s < NCS; s++) begin : g_cordic
    logic signed [CW-1:0] x1, y1, z1, x2, y2, z2;

    always_comb begin
      if (!cz_q[s][CW-1]) begin
        x1 = cx_q[s] - (cy_q[s] >>> (2 * s));
        y1 = cy_q[s] + (cx_q[s] >>> (2 * s));
        z1 = cz_q[s] - CW'(rsct_pkg::ATAN_TURNS[2 * s]);
      end else begin
        x1 = cx_q[s] + (cy_q[s] >>> (2 * s));
        y1 = cy_q[s] - (cx_q[s] >>> (2 * s));
        z1 = cz_q[s] + CW'(rsct_pkg::ATAN_TURNS[2 * s]);
      end
      if (!z1[CW-1]) begin
        x2 = x1 - (y1 >>> (2 * s + 1));
        y2 = y1 + (x1 >>> (2 * s + 1));
        z2 = z1 - CW'(rsct_pkg::ATAN_TURNS[2 * s + 1]);
      end else begin
        x2 = x1 + (y1 >>> (2 * s + 1));
        y2 = y1 - (x1 >>> (2 * s + 1));
        z2 = z1 + CW'(rsct_pkg::ATAN_TURNS[2 * s + 1]);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[s+1] <= 1'b0;
      end else if (en) begin
        cv_q[s+1] <= cv_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        cx_q[s+1] <= x2;
        cy_q[s+1] <= y2;
        cz_q[s+1] <= z2;
        cf_q[s+1] <= cf_q[s];
        ci_q[s+1] <= ci_q[s];
        cl_q[s+1] <= cl_q[s];
      end
    end
  end

  // output stage: round to Q1.15, negate if folded, saturate
  function automatic logic signed [15:0] to_q15(input logic signed [CW-1:0] v,
                                                input logic neg);
    logic signed [CW-1:0] r;
    begin
      r = (v + CW'(64'sd16384)) >>> 15;
      if (neg) begin
        r = -r;
      end
      if (r > CW'(64'sd32767)) begin
        to_q15 = 16'sh7fff;
      end else if (r < -CW'(64'sd32768)) begin
        to_q15 = 16'sh8000;
      end else begin
        to_q15 = r[15:0];
      end
    end
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= cv_q[NCS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sin_value_o  <= to_q15(cy_q[NCS], cf_q[NCS]);
      cos_value_o  <= to_q15(cx_q[NCS], cf_q[NCS]);
      pair_index_o <= ci_q[NCS];
      last_o       <= cl_q[NCS];
    end
  end

  // a fresh position starts at index zero with unit power
  `RSCT_ASSERT_NEXT(a_start, in_valid_i && in_ready_o, busy_q && idx_q == '0 && pow_q == rsct_pkg::ONE_Q31)
  // the last pair releases the sequencer
  `RSCT_ASSERT_NEXT(a_release, issue && issue_last, !busy_q)
  // a non-final issue keeps the sequencer busy
  `RSCT_ASSERT_NEXT(a_hold_busy, issue && !issue_last, busy_q)
  // a held output freezes the sequencer
  `RSCT_ASSERT_NEXT(a_stall, busy_q && !en, $stable(idx_q) && $stable(pow_q))

endmodule

>>> sim/rotary_sin_cos_table_core_tb.sv
// Self-checking testbench for rotary_sin_cos_table_core: a bit-exact predictor of
// the sin/cos pairs per position, random idling on both sides, and config sweeps.
// Depends on rsct_pkg and the core RTL.
`timescale 1ns / 1ps

module rotary_sin_cos_table_core_tb;

  // Index 2 and 3 name no register, so the core must ignore writes to them.
  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;
  localparam int unsigned PAIRS_MAX  = 64;

  typedef struct packed {
    logic signed [15:0] sin_v;
    logic signed [15:0] cos_v;
    logic [5:0]         idx;
    logic               last;
  } pair_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = rsct_pkg::REG_THETA;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [15:0] position_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic signed [15:0] sin_value_o, cos_value_o;
  logic [5:0]  pair_index_o;
  logic        last_o;

  // Predictor copy of the registers
  logic [31:0] theta_reg = rsct_pkg::ONE_Q31;
  logic [6:0]  pairs_reg = 7'd64;

  pair_t pending_pairs[$];
  int    mismatches = 0;
  int    positions_sent = 0;
  int    pairs_checked = 0;
  bit    no_idle = 1'b0;

  rotary_sin_cos_table_core u_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .position_i, .out_valid_o, .out_ready_i,
    .sin_value_o, .cos_value_o, .pair_index_o, .last_o
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Gap length: mostly none or short, now and then long; none at all in steady stretches.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Round from Q2.30 to Q1.15 by rounding half up, negate on a folded half turn, saturate.
  function automatic logic [15:0] round_q15(input longint v, input bit flip);
    longint r;
    r = (v + 64'sd16384) >>> 15;
    if (flip) r = -r;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  // Fold the phase into a quarter turn either side of zero, then rotate 16 steps.
  task automatic cordic_rotate(input logic [31:0] ph, output logic [15:0] s,
                               output logic [15:0] c);
    longint z, x, y, dx, dy;
    bit flip;
    z = longint'(signed'(ph));
    x = longint'(rsct_pkg::CORDIC_GAIN);
    y = 0;
    flip = 1'b0;
    if (z > 64'sd1073741824) begin
      z -= 64'sd2147483648;
      flip = 1'b1;
    end else if (z < -64'sd1073741824) begin
      z += 64'sd2147483648;
      flip = 1'b1;
    end
    for (int k = 0; k < rsct_pkg::CORDIC_STEPS; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= longint'(rsct_pkg::ATAN_TURNS[k]);
      end else begin
        x += dx;
        y -= dy;
        z += longint'(rsct_pkg::ATAN_TURNS[k]);
      end
    end
    s = round_q15(y, flip);
    c = round_q15(x, flip);
  endtask

  // Queue every pair that one accepted position will produce.
  task automatic predict_pairs(input logic [15:0] pos);
    bit [63:0] power, freq, ph48, theta;
    int count;
    pair_t p;
    theta = (theta_reg > rsct_pkg::ONE_Q31) ? 64'(rsct_pkg::ONE_Q31) : 64'(theta_reg);
    count = (pairs_reg == 0) ? 1 : ((pairs_reg > PAIRS_MAX) ? PAIRS_MAX : pairs_reg);
    power = 64'(rsct_pkg::ONE_Q31);
    for (int i = 0; i < count; i++) begin
      freq = (power * 64'(rsct_pkg::INV_TWO_PI_Q32) + 64'd16384) >> 15;
      ph48 = (64'(pos) * freq) & 64'hFFFF_FFFF_FFFF;
      cordic_rotate(ph48[47:16], p.sin_v, p.cos_v);
      p.idx  = i[5:0];
      p.last = (i + 1 == count);
      pending_pairs.push_back(p);
      power = (power * theta + 64'd1073741824) >> 31;
    end
  endtask

  // Send one position beat; valid is left high so back-to-back beats need no drop.
  task automatic send_position(input logic [15:0] pos);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    position_i <= pos;
    do @(posedge clk_i); while (!in_ready_o);
    predict_pairs(pos);
    positions_sent++;
  endtask

  // Drop valid and hold until every predicted pair has come out.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk_i);
  endtask

  // Register write; only called when the core is idle.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == rsct_pkg::REG_THETA) theta_reg = data;
    else if (idx == rsct_pkg::REG_PAIRS) pairs_reg = data[6:0];
    @(posedge clk_i);
  endtask

  // Result side: check each beat against the oldest prediction, then pick ready.
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (pending_pairs.size() == 0) begin
        $display("%0t: unexpected pair beat idx=%0d", $time, pair_index_o);
        mismatches++;
      end else begin
        pair_t e;
        e = pending_pairs.pop_front();
        pairs_checked++;
        if (sin_value_o !== e.sin_v) begin
          $display("%0t: sin_value exp %0d got %0d", $time, e.sin_v, sin_value_o);
          mismatches++;
        end
        if (cos_value_o !== e.cos_v) begin
          $display("%0t: cos_value exp %0d got %0d", $time, e.cos_v, cos_value_o);
          mismatches++;
        end
        if (pair_index_o !== e.idx) begin
          $display("%0t: pair_index exp %0d got %0d", $time, e.idx, pair_index_o);
          mismatches++;
        end
        if (last_o !== e.last) begin
          $display("%0t: last exp %0d got %0d", $time, e.last, last_o);
          mismatches++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      int g;
      g = pick_gap();
      stall_left <= g;
      out_ready_i <= (g == 0);
    end
  end

  // Extremes of position under the reset configuration.
  task automatic test_position_extremes();
    send_position(16'd0);
    send_position(16'd1);
    send_position(16'hFFFF);
    send_position(16'h5555);
    send_position(16'hAAAA);
    send_position(16'h8000);
  endtask

  // Zero ratio, ratio above one, tiny ratio; pair counts of zero, one and too many.
  task automatic test_config_extremes();
    write_reg(rsct_pkg::REG_PAIRS, 32'd5);
    write_reg(rsct_pkg::REG_THETA, 32'd0);
    send_position(16'd12345);
    send_position(16'hFFFF);
    write_reg(rsct_pkg::REG_THETA, 32'hFFFF_FFFF);
    send_position(16'd777);
    write_reg(rsct_pkg::REG_THETA, 32'd1);
    send_position(16'd40000);
    write_reg(rsct_pkg::REG_PAIRS, 32'd0);
    send_position(16'd300);
    write_reg(rsct_pkg::REG_PAIRS, 32'd1);
    send_position(16'hFFFE);
    write_reg(rsct_pkg::REG_PAIRS, 32'd127);
    write_reg(rsct_pkg::REG_THETA, 32'h7FFF_FFFF);
    send_position(16'd9999);
    write_reg(rsct_pkg::REG_PAIRS, 32'hFFFF_FF41);
    send_position(16'd2);
  endtask

  // Writes to unused indexes must leave both registers alone.
  task automatic test_spare_index();
    write_reg(rsct_pkg::REG_PAIRS, 32'd3);
    write_reg(rsct_pkg::REG_THETA, 32'h6000_0000);
    write_reg(REG_SPARE_A, 32'd0);
    write_reg(REG_SPARE_B, 32'hFFFF_FFFF);
    send_position(16'd1000);
    send_position(16'd65000);
  endtask

  // Random positions across several settings; mostly small pair counts keep runs short.
  task automatic test_random_sweep();
    logic [31:0] th;
    logic [6:0]  pc;
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: th = $urandom_range(32'h4000_0000, rsct_pkg::ONE_Q31);
        1: th = $urandom();
        2: th = rsct_pkg::ONE_Q31 - $urandom_range(0, 32'h0100_0000);
        default: th = $urandom_range(0, 32'h1000);
      endcase
      pc = (ph == 5) ? 7'd64 : ((ph == 9) ? 7'd100 : 7'($urandom_range(1, 12)));
      write_reg(rsct_pkg::REG_THETA, th);
      write_reg(rsct_pkg::REG_PAIRS, {25'($urandom()), pc});
      no_idle = (ph % 3 == 2);
      for (int n = 0; n < ((pc >= 64) ? 6 : 23); n++) begin
        send_position(16'($urandom()));
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_position_extremes();
    test_config_extremes();
    test_spare_index();
    test_random_sweep();
    drain();
    repeat (40) @(posedge clk_i);
    $display("Covered %0d positions and %0d sin/cos pairs over ratio and pair-count sweeps,",
             positions_sent, pairs_checked);
    $display("including zero and over-one ratios, pair counts 0/1/64+ and unused indexes.");
    if (mismatches == 0 && pending_pairs.size() == 0) begin
      $display("rotary_sin_cos_table_core_tb OK");
    end else begin
      $display("rotary_sin_cos_table_core_tb NOT OK");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #40ms;
    $display("rotary_sin_cos_table_core_tb NOT OK");
    $finish;
  end

endmodule

>>> rotary_sin_cos_table_core.f
+incdir+rtl
rtl/rsct_pkg.sv
rtl/rotary_sin_cos_table_core.sv
sim/rotary_sin_cos_table_core_tb.sv
